// ----- hw/rtl/fbcd_pkg.sv -----
// Shared types and constants for the five-bit code dictionary unpacker.
package fbcd_pkg;

   localparam int CODE_W   = 5;
   localparam int SYM_W    = 8;
   localparam int CARRY_W  = 4;

   localparam logic [CODE_W-1:0] END_CODE = 5'd31;

   localparam logic OP_DATA = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // position of the next byte within its five-byte group
   typedef enum logic [2:0] {
      PH_B0 = 3'd0,
      PH_B1 = 3'd1,
      PH_B2 = 3'd2,
      PH_B3 = 3'd3,
      PH_B4 = 3'd4
   } phase_type;

   // codes pulled out of one data byte
   typedef struct packed {
      logic [CODE_W-1:0] code0;
      logic [CODE_W-1:0] code1;
      logic              two;
      logic              end0;
      logic              end1;
   } codes_type;

endpackage

// ----- hw/rtl/five_bit_code_dictionary_unpacker.sv -----
// Five-bit code dictionary unpacker top level.
// A data word's first result is shown the cycle after it is accepted.
// One word per cycle while each gives one result and the output is not stalled; a
//   word that gives two holds off the next until its second is taken. The single
//   result register and two-word sequencer set this; loads and post-end words give none.
// Reset (synchronous) clears phase, carry, stop flag and pending results; the table
//   keeps its contents and must be loaded before use.
module five_bit_code_dictionary_unpacker
   import fbcd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 31
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic [CODE_W-1:0] req_index,
   input  logic [SYM_W-1:0]  req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [SYM_W-1:0]  rsp_symbol,
   output logic              rsp_end_seen,
   output logic              rsp_last
);

   codes_type        codes;
   logic             stopped;
   logic             busy;
   logic             accept, take, tbl_wr;
   logic [SYM_W-1:0] sym0, sym1;

   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;
   assign take      = accept && (req_op == OP_DATA) && !stopped;
   assign tbl_wr    = accept && (req_op == OP_LOAD);

   fbcd_split u_split (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .value   (req_value),
      .codes   (codes),
      .stopped (stopped)
   );

   fbcd_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock    (clock),
      .wr_en    (tbl_wr),
      .wr_index (req_index),
      .wr_value (req_value),
      .rd_en    (take),
      .rd_code0 (codes.code0),
      .rd_code1 (codes.code1),
      .rd_sym0  (sym0),
      .rd_sym1  (sym1)
   );

   fbcd_resp u_resp (
      .clock        (clock),
      .reset        (reset),
      .load         (take),
      .codes        (codes),
      .sym0         (sym0),
      .sym1         (sym1),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_symbol   (rsp_symbol),
      .rsp_end_seen (rsp_end_seen),
      .rsp_last     (rsp_last),
      .busy         (busy)
   );

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_seen |-> (rsp_symbol == '0) && rsp_last)
      else $error("end marker word carries a symbol or is not last");

   a_end_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_seen |-> stopped)
      else $error("end marker shown but decoder not stopped");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid && rsp_last)
      else $error("first of two words not followed by the last one");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      take |-> !(rsp_valid && !(rsp_last && !rsp_stall)))
      else $error("data word taken while results still pending");

endmodule

// ----- hw/rtl/fbcd_split.sv -----
// Bit splitter: phase and carry tracking that cuts packed bytes into 5-bit codes.
module fbcd_split
   import fbcd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [SYM_W-1:0] value,
   output codes_type        codes,
   output logic             stopped
);

   phase_type          phase_ff, phase_in;
   logic [CARRY_W-1:0] carry_ff, carry_in;
   logic               stopped_ff, stopped_in;
   logic [CARRY_W-1:0] carry_nx;
   logic [CODE_W-1:0]  c0, c1;
   logic               two;

   // next phase
   always_comb begin
      unique case (phase_ff)
         PH_B0:   phase_in = PH_B1;
         PH_B1:   phase_in = PH_B2;
         PH_B2:   phase_in = PH_B3;
         PH_B3:   phase_in = PH_B4;
         PH_B4:   phase_in = PH_B0;
         default: phase_in = PH_B1;
      endcase
   end

   // code extraction per phase
   always_comb begin
      c1 = '0;
      unique case (phase_ff)
         PH_B1: begin
            c0       = {carry_ff[2:0], value[7:6]};
            c1       = value[5:1];
            two      = 1'b1;
            carry_nx = {3'b000, value[0]};
         end
         PH_B2: begin
            c0       = {carry_ff[0], value[7:4]};
            two      = 1'b0;
            carry_nx = value[3:0];
         end
         PH_B3: begin
            c0       = {carry_ff[3:0], value[7]};
            c1       = value[6:2];
            two      = 1'b1;
            carry_nx = {2'b00, value[1:0]};
         end
         PH_B4: begin
            c0       = {carry_ff[1:0], value[7:5]};
            c1       = value[4:0];
            two      = 1'b1;
            carry_nx = '0;
         end
         default: begin
            // first byte of a group, also for unused phase codes
            c0       = value[7:3];
            two      = 1'b0;
            carry_nx = {1'b0, value[2:0]};
         end
      endcase
   end

   assign codes.code0 = c0;
   assign codes.code1 = c1;
   assign codes.two   = two;
   assign codes.end0  = (c0 == END_CODE);
   assign codes.end1  = two && (c1 == END_CODE);

   assign carry_in   = carry_nx;
   assign stopped_in = stopped_ff || codes.end0 || codes.end1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_B0;
         carry_ff   <= '0;
         stopped_ff <= 1'b0;
      end else if (take) begin
         phase_ff   <= phase_in;
         carry_ff   <= carry_in;
         stopped_ff <= stopped_in;
      end
   end

   assign stopped = stopped_ff;

endmodule

// ----- hw/rtl/fbcd_table.sv -----
// Symbol table: one write port, two registered read ports.
module fbcd_table
   import fbcd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 31
)
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [CODE_W-1:0] wr_index,
   input  logic [SYM_W-1:0]  wr_value,
   input  logic              rd_en,
   input  logic [CODE_W-1:0] rd_code0,
   input  logic [CODE_W-1:0] rd_code1,
   output logic [SYM_W-1:0]  rd_sym0,
   output logic [SYM_W-1:0]  rd_sym1
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [CODE_W-1:0] LIMIT = CODE_W'(TABLE_ENTRIES);

   logic [SYM_W-1:0] mem [TABLE_ENTRIES];
   logic [SYM_W-1:0] sym0_ff, sym1_ff;
   logic             hit0, hit1;

   // the end code never reaches the table: LIMIT is at most 31
   assign hit0 = (rd_code0 < LIMIT);
   assign hit1 = (rd_code1 < LIMIT);

   always_ff @(posedge clock) begin
      if (wr_en && (wr_index < LIMIT)) begin
         mem[wr_index[AW-1:0]] <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         sym0_ff <= hit0 ? mem[rd_code0[AW-1:0]] : '0;
         sym1_ff <= hit1 ? mem[rd_code1[AW-1:0]] : '0;
      end
   end

   assign rd_sym0 = sym0_ff;
   assign rd_sym1 = sym1_ff;

endmodule

// ----- hw/rtl/fbcd_resp.sv -----
// Result sequencer: holds one byte's decode and hands out its one or two words.
module fbcd_resp
   import fbcd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  codes_type        codes,
   input  logic [SYM_W-1:0] sym0,
   input  logic [SYM_W-1:0] sym1,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic [SYM_W-1:0] rsp_symbol,
   output logic             rsp_end_seen,
   output logic             rsp_last,
   output logic             busy
);

   logic pend_ff, pend_in;
   logic sel_ff, sel_in;
   logic two_ff, end0_ff, end1_ff;
   logic fire, done;

   assign fire = pend_ff && !rsp_stall;
   assign done = fire && rsp_last;
   assign busy = pend_ff && !done;

   always_comb begin
      pend_in = pend_ff;
      sel_in  = sel_ff;
      if (load) begin
         pend_in = 1'b1;
         sel_in  = 1'b0;
      end else if (done) begin
         pend_in = 1'b0;
         sel_in  = 1'b0;
      end else if (fire) begin
         sel_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         sel_ff  <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         sel_ff  <= sel_in;
      end
   end

   // an end in the first code drops the second one
   always_ff @(posedge clock) begin
      if (load) begin
         two_ff  <= codes.two && !codes.end0;
         end0_ff <= codes.end0;
         end1_ff <= codes.end1;
      end
   end

   assign rsp_valid    = pend_ff;
   assign rsp_end_seen = sel_ff ? end1_ff : end0_ff;
   assign rsp_last     = sel_ff || !two_ff;
   assign rsp_symbol   = rsp_end_seen ? '0 : (sel_ff ? sym1 : sym0);

endmodule

// ----- tb/testbench.sv -----
// Testbench for the five-bit code dictionary unpacker: random stream checked against a predictor.
module testbench;
   import fbcd_pkg::*;

   localparam int DICT_ENTRIES = 31;

   typedef struct {
      logic [SYM_W-1:0] symbol;
      logic             end_seen;
      logic             last;
   } symbol_word_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_op;
   logic [CODE_W-1:0] req_index;
   logic [SYM_W-1:0]  req_value;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [SYM_W-1:0]  rsp_symbol;
   logic              rsp_end_seen;
   logic              rsp_last;

   // predictor state
   logic [SYM_W-1:0]   exp_dict [DICT_ENTRIES];
   phase_type          exp_phase;
   logic [CARRY_W-1:0] exp_carry;
   logic               exp_stopped;
   symbol_word_type    pending_symbols [$];

   int  mismatch_count = 0;
   int  burst_left = 0;
   bit  steady_send = 0;
   bit  hold_request = 0;
   int  hold_left = 0;
   int  stall_mode = 0;
   int  stall_mode_left = 0;

   five_bit_code_dictionary_unpacker #(.TABLE_ENTRIES(DICT_ENTRIES)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_index(req_index),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_symbol(rsp_symbol),
      .rsp_end_seen(rsp_end_seen),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

   // codes carried by one data byte at a given group position
   function automatic codes_type split_byte(input phase_type ph, input logic [CARRY_W-1:0] cin,
                                            input logic [SYM_W-1:0] v,
                                            output logic [CARRY_W-1:0] cout);
      codes_type c;
      c = '0;
      case (ph)
         PH_B0: begin
            c.code0 = v[7:3];
            cout = {1'b0, v[2:0]};
         end
         PH_B1: begin
            c.code0 = {cin[2:0], v[7:6]};
            c.code1 = v[5:1];
            c.two = 1'b1;
            cout = {3'b000, v[0]};
         end
         PH_B2: begin
            c.code0 = {cin[0], v[7:4]};
            cout = v[3:0];
         end
         PH_B3: begin
            c.code0 = {cin[3:0], v[7]};
            c.code1 = v[6:2];
            c.two = 1'b1;
            cout = {2'b00, v[1:0]};
         end
         default: begin
            c.code0 = {cin[1:0], v[7:5]};
            c.code1 = v[4:0];
            c.two = 1'b1;
            cout = '0;
         end
      endcase
      c.end0 = (c.code0 == END_CODE);
      c.end1 = c.two && (c.code1 == END_CODE);
      return c;
   endfunction

   // random data byte that keeps the stream alive
   function automatic logic [SYM_W-1:0] live_byte();
      logic [SYM_W-1:0]   v;
      logic [CARRY_W-1:0] unused_carry;
      codes_type          c;
      do begin
         v = SYM_W'($urandom_range(0, 255));
         c = split_byte(exp_phase, exp_carry, v, unused_carry);
      end while (c.end0 || c.end1);
      return v;
   endfunction

   function automatic symbol_word_type lookup(input logic [CODE_W-1:0] code, input logic fin);
      symbol_word_type w;
      w.symbol = (code < DICT_ENTRIES) ? exp_dict[code] : '0;
      w.end_seen = 1'b0;
      w.last = fin;
      return w;
   endfunction

   task automatic predict_word(input logic op, input logic [CODE_W-1:0] idx,
                               input logic [SYM_W-1:0] val);
      codes_type          c;
      logic [CARRY_W-1:0] next_carry;
      symbol_word_type    end_word;
      end_word.symbol = '0;
      end_word.end_seen = 1'b1;
      end_word.last = 1'b1;
      if (op == OP_LOAD) begin
         if (idx < DICT_ENTRIES) exp_dict[idx] = val;
      end else if (!exp_stopped) begin
         c = split_byte(exp_phase, exp_carry, val, next_carry);
         exp_carry = next_carry;
         exp_phase = (exp_phase == PH_B4) ? PH_B0 : phase_type'(exp_phase + 3'd1);
         if (c.end0) begin
            // second code of the byte is dropped
            pending_symbols.push_back(end_word);
            exp_stopped = 1'b1;
         end else if (!c.two) begin
            pending_symbols.push_back(lookup(c.code0, 1'b1));
         end else begin
            pending_symbols.push_back(lookup(c.code0, 1'b0));
            if (c.end1) begin
               pending_symbols.push_back(end_word);
               exp_stopped = 1'b1;
            end else begin
               pending_symbols.push_back(lookup(c.code1, 1'b1));
            end
         end
      end
   endtask

   task automatic send_word(input logic op, input logic [CODE_W-1:0] idx,
                            input logic [SYM_W-1:0] val);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (!steady_send && gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op <= op;
      req_index <= idx;
      req_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(op, idx, val);
   endtask

   task automatic send_data(input logic [SYM_W-1:0] val);
      send_word(OP_DATA, CODE_W'($urandom_range(0, 31)), val);
   endtask

   // sender pauses until every expected word is back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_dictionary();
      for (int i = 0; i < DICT_ENTRIES; i++) begin
         if (i == 0) send_word(OP_LOAD, CODE_W'(i), 8'h00);
         else if (i == DICT_ENTRIES - 1) send_word(OP_LOAD, CODE_W'(i), 8'hFF);
         else send_word(OP_LOAD, CODE_W'(i), SYM_W'($urandom_range(0, 255)));
      end
      // index past the table is dropped
      send_word(OP_LOAD, 5'd31, SYM_W'($urandom_range(0, 255)));
   endtask

   task automatic check_code_extremes();
      logic [SYM_W-1:0] bytes [15];
      bytes = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'hE0,    // mostly zero codes, 0xFF mid group
                8'hF7, 8'hBD, 8'hEF, 8'h7B, 8'hDE,    // code 30 in every slot
                8'h07, 8'h81, 8'hE0, 8'h78, 8'h1E};   // 0 and 30 alternating
      for (int i = 0; i < 15; i++) begin
         send_data(bytes[i]);
         if (i == 7) send_word(OP_LOAD, 5'd5, SYM_W'($urandom_range(0, 255)));
      end
      drain();
   endtask

   task automatic random_items(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_word(OP_LOAD, CODE_W'($urandom_range(0, 31)), SYM_W'($urandom_range(0, 255)));
         else
            send_data(live_byte());
      end
   endtask

   task automatic check_random_stream();
      random_items(350);
      drain();
      random_items(300);
   endtask

   task automatic check_output_backpressure();
      hold_request = 1'b1;
      steady_send = 1'b1;
      random_items(40);
      steady_send = 1'b0;
      random_items(300);
      drain();
   endtask

   task automatic check_end_code();
      while (exp_phase != PH_B0) send_data(live_byte());
      // end code lands in the first of the two codes of the second byte
      send_data({CODE_W'($urandom_range(0, 30)), 3'b111});
      send_data({2'b11, 6'($urandom_range(0, 63))});
      send_data(8'hFF);
      send_data(8'h00);
      send_word(OP_LOAD, 5'd3, SYM_W'($urandom_range(0, 255)));
      send_word(OP_LOAD, 5'd31, SYM_W'($urandom_range(0, 255)));
      for (int i = 0; i < 4; i++) send_data(SYM_W'($urandom_range(0, 255)));
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 80;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 150);
         end
         stall_mode_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= stall_mode_left[1];
         endcase
      end
   end

   always @(posedge clock) begin
      symbol_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_symbols.size() == 0) begin
            $error("unexpected word: symbol %0h end_seen %0b last %0b",
                   rsp_symbol, rsp_end_seen, rsp_last);
            mismatch_count++;
         end else begin
            want = pending_symbols.pop_front();
            if (rsp_symbol !== want.symbol) begin
               $error("symbol: expected %0h, got %0h", want.symbol, rsp_symbol);
               mismatch_count++;
            end
            if (rsp_end_seen !== want.end_seen) begin
               $error("end_seen: expected %0b, got %0b", want.end_seen, rsp_end_seen);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      req_valid <= 1'b0;
      req_op <= OP_DATA;
      req_index <= '0;
      req_value <= '0;
      reset <= 1'b1;
      foreach (exp_dict[i]) exp_dict[i] = '0;
      exp_phase = PH_B0;
      exp_carry = '0;
      exp_stopped = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      load_dictionary();
      check_code_extremes();
      check_random_stream();
      check_output_backpressure();
      check_end_code();

      req_valid <= 1'b0;
      for (int i = 0; i < 5000 && pending_symbols.size() != 0; i++) @(posedge clock);
      if (pending_symbols.size() != 0) begin
         $error("%0d expected words never arrived", pending_symbols.size());
         mismatch_count++;
      end
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
